### rtl/core/htbl_pkg.sv
// types and constants shared by the handle table block
// no dependencies

package htbl_pkg;

    localparam logic [2:0] OP_ADD      = 3'd0;
    localparam logic [2:0] OP_ROOM     = 3'd1;
    localparam logic [2:0] OP_GET      = 3'd2;
    localparam logic [2:0] OP_REMOVE   = 3'd3;
    localparam logic [2:0] OP_BEGIN    = 3'd4;
    localparam logic [2:0] OP_COMPLETE = 3'd5;
    localparam logic [2:0] OP_CANCEL   = 3'd6;

    localparam logic [2:0] STS_OK         = 3'd0;
    localparam logic [2:0] STS_INVALID    = 3'd1;
    localparam logic [2:0] STS_BUSY       = 3'd2;
    localparam logic [2:0] STS_NO_HANDLES = 3'd3;
    localparam logic [2:0] STS_FULL       = 3'd4;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [31:0] handle_in;
        logic [31:0] object_ref_in;
        logic [31:0] batch_count;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] handle_out;
        logic [31:0] object_ref_out;
    } resp_t;

    typedef struct packed {
        logic        valid;
        logic        busy;
        logic [31:0] key;
        logic [31:0] obj_ref;
    } entry_t;

    typedef struct packed {
        logic hit;
        logic busy;
    } match_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_RESP
    } state_t;

endpackage

### rtl/core/handle_table_with_busy_marks.sv
// handle table top level: sequencer, handle counter and output register
// depends on htbl_pkg, htbl_mem, htbl_match
//
// requests arrive on req (valid/ready), one result per request leaves on resp
// (valid/ready). each transfer on req carries an opcode, a handle, an object
// reference and a batch count; each transfer on resp carries a status, the
// handle given out by add and the returned object reference.
// add and the lookup operations scan the entry store one slot per cycle
// through a single compare unit, reading the store with one registered port.
// a scan ends at the first hit or at the last slot; room check, unused opcodes
// and add with the counter wrapped skip the scan and go straight to the result.
// req_ready is high only while no request is in progress; a finished result
// waits in the output register, so the next request is taken while resp is
// stalled. a result that finds the output register still full waits.
// after reset the block clears the valid and busy marks of the store, one
// slot per cycle, and holds req_ready low until every slot is cleared. the
// handle counter restarts at 1.

module handle_table_with_busy_marks
    import htbl_pkg::*;
#(
    parameter int TABLE_ENTRIES = 64
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  req_valid,
    output logic  req_ready,
    input  req_t  req,
    output logic  resp_valid,
    input  logic  resp_ready,
    output resp_t resp
);

    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam logic [AW-1:0] LAST = AW'(TABLE_ENTRIES - 1);

    state_t        state_reg, state_next;
    req_t          req_reg, req_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [AW-1:0] lag_idx_reg, lag_idx_next;
    logic          lag_valid_reg, lag_valid_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic [31:0]   handle_reg, handle_next;
    resp_t         res_reg, res_next;
    logic          out_valid_reg, out_valid_next;
    resp_t         out_reg, out_next;

    logic          we;
    logic [AW-1:0] waddr;
    entry_t        wdata;
    entry_t        rdata;
    match_t        match;
    logic [32:0]   room_sum;

    htbl_mem #(
        .DEPTH (TABLE_ENTRIES),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (idx_reg),
        .rdata (rdata)
    );

    htbl_match u_match (
        .word      (rdata),
        .find_free (req_reg.opcode == OP_ADD),
        .handle    (req_reg.handle_in),
        .result    (match)
    );

    assign room_sum = {1'b0, handle_reg} + {1'b0, req.batch_count};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            idx_reg       <= '0;
            lag_idx_reg   <= '0;
            lag_valid_reg <= 1'b0;
            clr_reg       <= '0;
            handle_reg    <= 32'd1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            lag_idx_reg   <= lag_idx_next;
            lag_valid_reg <= lag_valid_next;
            clr_reg       <= clr_next;
            handle_reg    <= handle_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        res_reg <= res_next;
        out_reg <= out_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        idx_next       = idx_reg;
        lag_idx_next   = lag_idx_reg;
        lag_valid_next = lag_valid_reg;
        clr_next       = clr_reg;
        handle_next    = handle_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && !resp_ready;
        out_next       = out_reg;
        we             = 1'b0;
        waddr          = lag_idx_reg;
        wdata          = rdata;
        req_ready      = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                we       = 1'b1;
                waddr    = clr_reg;
                wdata    = '0;
                clr_next = clr_reg + AW'(1);
                if (clr_reg == LAST)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                req_ready      = 1'b1;
                idx_next       = '0;
                lag_valid_next = 1'b0;
                if (req_valid)
                begin
                    req_next = req;
                    res_next = '{status: STS_INVALID, handle_out: '0, object_ref_out: '0};
                    case (req.opcode) inside
                        OP_ADD:
                        begin
                            if (handle_reg == '0)
                            begin
                                res_next.status = STS_NO_HANDLES;
                                state_next      = ST_RESP;
                            end
                            else
                            begin
                                state_next = ST_SCAN;
                            end
                        end
                        OP_ROOM:
                        begin
                            if (handle_reg == '0 || room_sum[32])
                            begin
                                res_next.status = STS_NO_HANDLES;
                            end
                            else
                            begin
                                res_next.status = STS_OK;
                            end
                            state_next = ST_RESP;
                        end
                        OP_GET, OP_REMOVE, OP_BEGIN, OP_COMPLETE, OP_CANCEL:
                        begin
                            state_next = ST_SCAN;
                        end
                        default:
                        begin
                            state_next = ST_RESP;
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                idx_next       = (idx_reg == LAST) ? idx_reg : idx_reg + AW'(1);
                lag_idx_next   = idx_reg;
                lag_valid_next = 1'b1;
                if (lag_valid_reg)
                begin
                    res_next = '{status: STS_INVALID, handle_out: '0, object_ref_out: '0};
                    if (match.hit)
                    begin
                        state_next = ST_RESP;
                        case (req_reg.opcode)
                            OP_ADD:
                            begin
                                we          = 1'b1;
                                wdata       = '{valid: 1'b1, busy: 1'b0, key: handle_reg,
                                                obj_ref: req_reg.object_ref_in};
                                handle_next = handle_reg + 32'd1;
                                res_next.status     = STS_OK;
                                res_next.handle_out = handle_reg;
                            end
                            OP_GET:
                            begin
                                res_next.status         = STS_OK;
                                res_next.object_ref_out = rdata.obj_ref;
                            end
                            OP_REMOVE:
                            begin
                                if (match.busy)
                                begin
                                    res_next.status = STS_BUSY;
                                end
                                else
                                begin
                                    we                      = 1'b1;
                                    wdata.valid             = 1'b0;
                                    res_next.status         = STS_OK;
                                    res_next.object_ref_out = rdata.obj_ref;
                                end
                            end
                            OP_BEGIN:
                            begin
                                if (match.busy)
                                begin
                                    res_next.status = STS_BUSY;
                                end
                                else
                                begin
                                    we                      = 1'b1;
                                    wdata.busy              = 1'b1;
                                    res_next.status         = STS_OK;
                                    res_next.object_ref_out = rdata.obj_ref;
                                end
                            end
                            OP_COMPLETE:
                            begin
                                if (match.busy)
                                begin
                                    we              = 1'b1;
                                    wdata.valid     = 1'b0;
                                    wdata.busy      = 1'b0;
                                    res_next.status = STS_OK;
                                end
                            end
                            OP_CANCEL:
                            begin
                                if (match.busy)
                                begin
                                    we              = 1'b1;
                                    wdata.busy      = 1'b0;
                                    res_next.status = STS_OK;
                                end
                            end
                            default:
                            begin
                                res_next.status = STS_INVALID;
                            end
                        endcase
                    end
                    else if (lag_idx_reg == LAST)
                    begin
                        state_next = ST_RESP;
                        if (req_reg.opcode == OP_ADD)
                        begin
                            res_next.status = STS_FULL;
                        end
                    end
                end
            end

            ST_RESP:
            begin
                if (!out_valid_reg || resp_ready)
                begin
                    out_valid_next = 1'b1;
                    out_next       = res_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign resp_valid = out_valid_reg;
    assign resp       = out_reg;

endmodule

### rtl/core/htbl_mem.sv
// entry store: one write port, one read port with registered read data
// depends on htbl_pkg

module htbl_mem
    import htbl_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = $clog2(DEPTH)
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  entry_t        wdata,
    input  logic [AW-1:0] raddr,
    output entry_t        rdata
);

    entry_t mem [DEPTH];
    entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/htbl_match.sv
// shared compare unit: tests one stored entry against the request
// depends on htbl_pkg

module htbl_match
    import htbl_pkg::*;
(
    input  entry_t      word,
    input  logic        find_free,
    input  logic [31:0] handle,
    output match_t      result
);

    always_comb
    begin
        if (find_free)
        begin
            result.hit = !word.valid;
        end
        else
        begin
            result.hit = word.valid && (word.key == handle);
        end
        result.busy = word.busy;
    end

endmodule

### bench/handle_table_checker.sv
// checker for the handle table: watches the req and resp channels, predicts each result
// from its own model of the table and compares field by field
// depends on htbl_pkg

module handle_table_checker
    import htbl_pkg::*;
#(
    parameter int TABLE_ENTRIES = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    input  logic        req_ready,
    input  req_t        req,
    input  logic        resp_valid,
    input  logic        resp_ready,
    input  resp_t       resp,
    output int          fail_count,
    output int          pending,
    output logic [31:0] next_handle
);

    timeunit 1ns;
    timeprecision 1ps;

    logic [31:0] handle_ctr;
    logic        slot_valid [TABLE_ENTRIES];
    logic        slot_busy  [TABLE_ENTRIES];
    logic [31:0] slot_key   [TABLE_ENTRIES];
    logic [31:0] slot_obj   [TABLE_ENTRIES];
    resp_t       expected_resp_q [$];
    resp_t       oldest;

    assign next_handle = handle_ctr;

    function automatic int find_handle(logic [31:0] h);
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            if (slot_valid[i] && slot_key[i] == h)
                return i;
        end
        return -1;
    endfunction

    // updates the table model and returns the result the block should give
    function automatic resp_t apply_request(req_t r);
        resp_t       e;
        int          s;
        int          free_slot;
        logic [31:0] sum;
        e = '{status: STS_INVALID, handle_out: 32'd0, object_ref_out: 32'd0};
        s = find_handle(r.handle_in);
        free_slot = -1;
        sum = handle_ctr + r.batch_count;
        case (r.opcode)
            OP_ADD:
            begin
                for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
                begin
                    if (!slot_valid[i])
                        free_slot = i;
                end
                if (handle_ctr == 32'd0)
                    e.status = STS_NO_HANDLES;
                else if (free_slot < 0)
                    e.status = STS_FULL;
                else
                begin
                    slot_valid[free_slot] = 1'b1;
                    slot_busy[free_slot]  = 1'b0;
                    slot_key[free_slot]   = handle_ctr;
                    slot_obj[free_slot]   = r.object_ref_in;
                    e.status     = STS_OK;
                    e.handle_out = handle_ctr;
                    handle_ctr   = handle_ctr + 32'd1;
                end
            end
            OP_ROOM:
            begin
                if (handle_ctr == 32'd0 || sum < handle_ctr)
                    e.status = STS_NO_HANDLES;
                else
                    e.status = STS_OK;
            end
            OP_GET:
            begin
                if (s >= 0)
                begin
                    e.status         = STS_OK;
                    e.object_ref_out = slot_obj[s];
                end
            end
            OP_REMOVE:
            begin
                if (s >= 0 && slot_busy[s])
                    e.status = STS_BUSY;
                else if (s >= 0)
                begin
                    e.status         = STS_OK;
                    e.object_ref_out = slot_obj[s];
                    slot_valid[s]    = 1'b0;
                end
            end
            OP_BEGIN:
            begin
                if (s >= 0 && slot_busy[s])
                    e.status = STS_BUSY;
                else if (s >= 0)
                begin
                    e.status         = STS_OK;
                    e.object_ref_out = slot_obj[s];
                    slot_busy[s]     = 1'b1;
                end
            end
            OP_COMPLETE:
            begin
                if (s >= 0 && slot_busy[s])
                begin
                    e.status      = STS_OK;
                    slot_valid[s] = 1'b0;
                    slot_busy[s]  = 1'b0;
                end
            end
            OP_CANCEL:
            begin
                if (s >= 0 && slot_busy[s])
                begin
                    e.status     = STS_OK;
                    slot_busy[s] = 1'b0;
                end
            end
            default:
                e.status = STS_INVALID;
        endcase
        return e;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            handle_ctr = 32'd1;
            for (int i = 0; i < TABLE_ENTRIES; i++)
            begin
                slot_valid[i] = 1'b0;
                slot_busy[i]  = 1'b0;
                slot_key[i]   = 32'd0;
                slot_obj[i]   = 32'd0;
            end
            expected_resp_q.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            if (resp_valid && resp_ready)
            begin
                if (expected_resp_q.size() == 0)
                begin
                    $display("%0t: unexpected result status %0d handle %h ref %h", $time,
                             resp.status, resp.handle_out, resp.object_ref_out);
                    fail_count++;
                end
                else
                begin
                    oldest = expected_resp_q.pop_front();
                    if (resp.status !== oldest.status)
                    begin
                        $display("%0t: status expected %0d, got %0d", $time,
                                 oldest.status, resp.status);
                        fail_count++;
                    end
                    if (resp.handle_out !== oldest.handle_out)
                    begin
                        $display("%0t: handle_out expected %h, got %h", $time,
                                 oldest.handle_out, resp.handle_out);
                        fail_count++;
                    end
                    if (resp.object_ref_out !== oldest.object_ref_out)
                    begin
                        $display("%0t: object_ref_out expected %h, got %h", $time,
                                 oldest.object_ref_out, resp.object_ref_out);
                        fail_count++;
                    end
                end
            end
            if (req_valid && req_ready)
                expected_resp_q.push_back(apply_request(req));
            pending = expected_resp_q.size();
        end
    end

endmodule

### bench/tb_handle_table_with_busy_marks.sv
// top of the handle table testbench: clock, reset, request stimulus and verdict
// depends on htbl_pkg, handle_table_with_busy_marks and handle_table_checker

module tb_handle_table_with_busy_marks;

    timeunit 1ns;
    timeprecision 1ps;

    import htbl_pkg::*;

    localparam int         TABLE_ENTRIES = 64;
    localparam int         PHASE_ITEMS   = 213;
    localparam logic [2:0] OP_UNUSED     = 3'd7;

    logic        clk;
    logic        rst_n;
    logic        req_valid  = 1'b0;
    logic        req_ready;
    req_t        req        = '0;
    logic        resp_valid;
    logic        resp_ready = 1'b0;
    resp_t       resp;
    int          fail_count;
    int          pending;
    logic [31:0] pred_next_handle;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int items_sent     = 0;

    handle_table_with_busy_marks #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .resp_valid (resp_valid),
        .resp_ready (resp_ready),
        .resp       (resp)
    );

    handle_table_checker #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req         (req),
        .resp_valid  (resp_valid),
        .resp_ready  (resp_ready),
        .resp        (resp),
        .fail_count  (fail_count),
        .pending     (pending),
        .next_handle (pred_next_handle)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("handle_table_with_busy_marks regression: fail");
        $finish;
    end

    always @(posedge clk)
        resp_ready <= ($urandom_range(99) >= recv_stall_pct);

    // one request transfer; valid stays high into the next call when there is no gap
    task automatic issue(input logic [2:0] op, input logic [31:0] h,
                         input logic [31:0] obj, input logic [31:0] cnt);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req       <= '{opcode: op, handle_in: h, object_ref_in: obj, batch_count: cnt};
        req_valid <= 1'b1;
        do @(negedge clk); while (!req_ready);
        @(posedge clk);
        items_sent++;
    endtask

    // only recent handles, so that most lookups hit a live entry
    function automatic logic [31:0] pick_handle();
        logic [31:0] hi;
        logic [31:0] lo;
        hi = (pred_next_handle > 32'd1) ? pred_next_handle - 32'd1 : 32'd1;
        lo = (hi > 32'd90) ? hi - 32'd90 : 32'd1;
        return $urandom_range(hi, lo);
    endfunction

    initial
    begin
        logic [31:0] h;
        logic [31:0] cnt;
        int          add_pct;
        int          kind;

        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed part
        issue(OP_ADD,      $urandom(),   32'h0000_0000, $urandom());
        issue(OP_ADD,      $urandom(),   32'hFFFF_FFFF, $urandom());
        issue(OP_GET,      32'd1,        $urandom(),    $urandom());
        issue(OP_GET,      32'd2,        $urandom(),    $urandom());
        issue(OP_GET,      32'd0,        $urandom(),    $urandom());
        issue(OP_GET,      32'hFFFF_FFFF, $urandom(),   $urandom());
        issue(OP_ROOM,     $urandom(),   $urandom(),    32'h0000_0000);
        issue(OP_ROOM,     $urandom(),   $urandom(),    32'hFFFF_FFFF);
        issue(OP_ROOM,     $urandom(),   $urandom(),    32'hFFFF_FFFC);
        issue(OP_ROOM,     $urandom(),   $urandom(),    32'hFFFF_FFFD);
        issue(OP_BEGIN,    32'd1,        $urandom(),    $urandom());
        issue(OP_BEGIN,    32'd1,        $urandom(),    $urandom());
        issue(OP_REMOVE,   32'd1,        $urandom(),    $urandom());
        issue(OP_GET,      32'd1,        $urandom(),    $urandom());
        issue(OP_CANCEL,   32'd1,        $urandom(),    $urandom());
        issue(OP_CANCEL,   32'd1,        $urandom(),    $urandom());
        issue(OP_COMPLETE, 32'd1,        $urandom(),    $urandom());
        issue(OP_BEGIN,    32'd2,        $urandom(),    $urandom());
        issue(OP_COMPLETE, 32'd2,        $urandom(),    $urandom());
        issue(OP_GET,      32'd2,        $urandom(),    $urandom());
        issue(OP_REMOVE,   32'd1,        $urandom(),    $urandom());
        issue(OP_REMOVE,   32'd1,        $urandom(),    $urandom());
        issue(OP_UNUSED,   32'd1,        $urandom(),    $urandom());
        issue(OP_BEGIN,    32'd0,        $urandom(),    $urandom());

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
                default: begin send_idle_pct = 33; recv_stall_pct = 33; end
            endcase
            while (items_sent < 24 + PHASE_ITEMS * (phase + 1))
            begin
                // alternate filling and draining so the table runs full now and then
                add_pct = ((items_sent / 128) % 2 == 0) ? 60 : 15;
                h = pick_handle();
                if ($urandom_range(99) < add_pct)
                begin
                    issue(OP_ADD, $urandom(), $urandom(), $urandom());
                end
                else
                begin
                    kind = $urandom_range(9);
                    case (kind)
                        0: issue(OP_GET, h, $urandom(), $urandom());
                        1: issue(OP_REMOVE, h, $urandom(), $urandom());
                        2, 3:
                        begin
                            issue(OP_BEGIN, h, $urandom(), $urandom());
                            if ($urandom_range(1))
                                issue(OP_GET, h, $urandom(), $urandom());
                            if ($urandom_range(1))
                                issue(OP_COMPLETE, h, $urandom(), $urandom());
                            else
                                issue(OP_CANCEL, h, $urandom(), $urandom());
                        end
                        4:
                        begin
                            issue(OP_BEGIN, h, $urandom(), $urandom());
                            issue(OP_REMOVE, h, $urandom(), $urandom());
                            issue(OP_CANCEL, h, $urandom(), $urandom());
                            issue(OP_REMOVE, h, $urandom(), $urandom());
                        end
                        5:
                        begin
                            if ($urandom_range(1))
                                issue(OP_COMPLETE, h, $urandom(), $urandom());
                            else
                                issue(OP_CANCEL, h, $urandom(), $urandom());
                        end
                        6:
                        begin
                            case ($urandom_range(2))
                                0: cnt = $urandom();
                                1: cnt = 32'hFFFF_FFFF - pred_next_handle + $urandom_range(2);
                                default: cnt = $urandom_range(100);
                            endcase
                            issue(OP_ROOM, $urandom(), $urandom(), cnt);
                        end
                        7: issue(OP_BEGIN, h, $urandom(), $urandom());
                        8: issue(3'($urandom_range(7)), $urandom(), $urandom(), $urandom());
                        default:
                        begin
                            if ($urandom_range(1))
                                issue(OP_UNUSED, h, $urandom(), $urandom());
                            else
                                issue(3'($urandom_range(OP_CANCEL, OP_GET)), 32'd0,
                                      $urandom(), $urandom());
                        end
                    endcase
                end
            end
        end
        req_valid <= 1'b0;

        do @(negedge clk); while (pending != 0);
        repeat (TABLE_ENTRIES + 8) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("handle_table_with_busy_marks regression: pass");
        else
            $display("handle_table_with_busy_marks regression: fail");
        $finish;
    end

endmodule
